>>> rtl/vcwf_pkg.sv
package vcwf_pkg;

    localparam int MAX_COLUMNS     = 1024;
    localparam int MAX_LINES       = 1024;
    localparam int MAX_HALF_WINDOW = 31;
    localparam int WEIGHT_BITS     = 14;

    localparam int COL_W   = $clog2(MAX_COLUMNS);
    localparam int ROW_W   = $clog2(MAX_LINES);
    localparam int HALF_W  = $clog2(MAX_HALF_WINDOW + 1);
    localparam int ADDR_W  = ROW_W + COL_W;
    localparam int DIM_W   = 11;
    localparam int POS_W   = 10;
    localparam int SMP_W   = 32;
    localparam int WIN_W   = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int W_W     = WEIGHT_BITS + 1;
    localparam int PROD_W  = W_W + 1 + SMP_W;
    localparam int WSUM_W  = W_W + 2 * HALF_W + 2;
    localparam int SQ_W    = 2 * (WIN_W + 1);
    localparam int ROOT_W  = WIN_W + 1;
    localparam int SREM_W  = ROOT_W + 3;
    localparam int ACC_W   = WIN_W + HALF_W + 2;

    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_IDX_W = $clog2(DIV_NUM_W);
    localparam int DIV_CNT_W = DIV_IDX_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLUMNS   = 3'd0,
        CFG_LINES     = 3'd1,
        CFG_SPACING_X = 3'd2,
        CFG_SPACING_Y = 3'd3,
        CFG_NULL      = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE, S_HALF, S_BOUND, S_READ, S_CHECK, S_SQX, S_SQY, S_SQRT,
        S_WCHK, S_WDIV, S_MUL, S_ADD, S_FIN, S_FDIV, S_OUT
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] nbits;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } t_div_rsp;

endpackage

>>> rtl/vcwf_if.sv
interface vcwf_in_if;
    import vcwf_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    operation;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        column;
    logic signed [SMP_W-1:0] sample;
    logic [WIN_W-1:0]        window_width;
    modport source (output valid, operation, row, column, sample, window_width, input ready);
    modport sink   (input valid, operation, row, column, sample, window_width, output ready);
endinterface

interface vcwf_out_if;
    import vcwf_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] filtered_value;
    logic                    is_null;
    modport source (output valid, filtered_value, is_null, input ready);
    modport sink   (input valid, filtered_value, is_null, output ready);
endinterface

interface vcwf_cfg_if;
    import vcwf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/vcwf_div.sv
module vcwf_div
    import vcwf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_IDX_W-1:0] r_idx;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_quot;
    logic [DIV_DEN_W:0]   trial;
    logic                 fits;
    logic [DIV_DEN_W:0]   diff;
    logic [DIV_CNT_W-1:0] last;

    assign trial = {r_rem, r_num[r_idx]};
    assign fits  = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};
    assign last  = i_req.nbits - DIV_CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_idx  <= last[DIV_IDX_W-1:0];
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_quot <= '0;
            end else if (r_busy) begin
                r_rem  <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
                r_quot <= {r_quot[DIV_NUM_W-2:0], fits};
                if (r_idx == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_idx <= r_idx - DIV_IDX_W'(1);
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

>>> rtl/variable_cone_window_filter.sv
// Channel  | Dir | Payload                                         | Handshake
// i_in     | in  | operation, row, column, sample, window_width    | valid/ready
// o_out    | out | filtered_value, is_null                         | valid/ready
// i_cfg    | in  | index, data                                     | valid/ready
// A write item is stored while i_in is ready. A query walks its window one
// sample at a time: each is read and checked; one in the cone that is not null
// takes a 25-step square root and maybe a 38-step weight division. Half-size
// search and bounds come first; a 64-step division ends a non-null result.
// i_rst_n is synchronous; the frame store is not cleared.
// i_in is held off while a query runs and until its result is taken.
module variable_cone_window_filter
    import vcwf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    vcwf_in_if.sink     i_in,
    vcwf_out_if.source  o_out,
    vcwf_cfg_if.sink    i_cfg
);

    logic [SMP_W-1:0] mem [MAX_LINES*MAX_COLUMNS];

    logic [DIM_W-1:0]  r_cols, r_lines;
    logic [WIN_W-1:0]  r_sx, r_sy;
    logic [SMP_W-1:0]  r_null;

    t_state r_state, n_state;

    logic [POS_W-1:0]  r_i, r_j;
    logic [WIN_W-1:0]  r_win;
    logic [HALF_W-1:0] r_hx, r_hy;
    logic [ACC_W-1:0]  r_ax, r_ay;
    logic [COL_W-1:0]  r_left, r_right, r_x;
    logic [ROW_W-1:0]  r_bot, r_y;
    logic [SMP_W-1:0]  r_rd;
    logic              r_nonnull;
    logic [WIN_W-1:0]  r_xd, r_yd;
    logic [SQ_W-1:0]   r_sq;
    logic [SQ_W-1:0]   r_rad;
    logic [SREM_W-1:0] r_srem;
    logic [ROOT_W-1:0] r_root;
    logic [4:0]        r_cnt;
    logic [W_W-1:0]    r_w;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [DIV_NUM_W-1:0] r_sum;
    logic [WSUM_W-1:0] r_wsum;
    logic signed [SMP_W-1:0] r_res;
    logic              r_res_null;

    logic              in_acc, cfg_acc, out_acc;
    logic [WIN_W-1:0]  sxe, sye;
    logic [WIN_W:0]    two_sx, two_sy;
    logic              adv_x, adv_y;
    logic [DIM_W-1:0]  cols_e, lines_e, col_lim, line_lim;
    logic [DIM_W-1:0]  right_raw, bot_raw;
    logic [COL_W-1:0]  left_c, right_c;
    logic [ROW_W-1:0]  top_c, bot_c;
    logic              empty;
    logic [COL_W-1:0]  adx;
    logic [ROW_W-1:0]  ady;
    logic [COL_W+WIN_W-1:0] xd;
    logic [ROW_W+WIN_W-1:0] yd;
    logic              skip_xy, is_nul;
    logic              last_pos, advance;
    logic [SREM_W-1:0] srem2, strial;
    logic              sfits;
    logic              far;
    logic [WIN_W-1:0]  wdiff;
    logic [DIV_NUM_W-1:0] mag;
    logic              no_res;
    logic [DIV_NUM_W-1:0] q;
    logic [SMP_W-1:0]  qs;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    assign in_acc  = i_in.valid && i_in.ready;
    assign cfg_acc = i_cfg.valid && i_cfg.ready;
    assign out_acc = o_out.valid && o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = (r_state == S_OUT);
    assign o_out.filtered_value = r_res;
    assign o_out.is_null = r_res_null;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols  <= DIM_W'(1024);
            r_lines <= DIM_W'(1024);
            r_sx    <= WIN_W'(256);
            r_sy    <= WIN_W'(256);
            r_null  <= '0;
        end else if (cfg_acc) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_COLUMNS:   r_cols  <= i_cfg.data[DIM_W-1:0];
                CFG_LINES:     r_lines <= i_cfg.data[DIM_W-1:0];
                CFG_SPACING_X: r_sx    <= i_cfg.data[WIN_W-1:0];
                CFG_SPACING_Y: r_sy    <= i_cfg.data[WIN_W-1:0];
                CFG_NULL:      r_null  <= i_cfg.data[SMP_W-1:0];
                default: ;
            endcase
        end
    end

    // frame store
    always_ff @(posedge i_clk) begin
        if (in_acc && !i_in.operation) begin
            mem[{i_in.row[ROW_W-1:0], i_in.column[COL_W-1:0]}] <= i_in.sample;
        end
        if (r_state == S_READ) begin
            r_rd <= mem[{r_y, r_x}];
        end
    end

    assign sxe    = (r_sx == '0) ? WIN_W'(1) : r_sx;
    assign sye    = (r_sy == '0) ? WIN_W'(1) : r_sy;
    assign two_sx = {sxe, 1'b0};
    assign two_sy = {sye, 1'b0};
    assign adv_x  = (r_hx < HALF_W'(MAX_HALF_WINDOW)) && (r_ax <= ACC_W'(r_win));
    assign adv_y  = (r_hy < HALF_W'(MAX_HALF_WINDOW)) && (r_ay <= ACC_W'(r_win));

    assign cols_e  = (r_cols == '0) ? DIM_W'(1) :
                     (r_cols > DIM_W'(MAX_COLUMNS)) ? DIM_W'(MAX_COLUMNS) : r_cols;
    assign lines_e = (r_lines == '0) ? DIM_W'(1) :
                     (r_lines > DIM_W'(MAX_LINES)) ? DIM_W'(MAX_LINES) : r_lines;
    assign col_lim  = cols_e - DIM_W'(1);
    assign line_lim = lines_e - DIM_W'(1);
    assign right_raw = DIM_W'(r_j) + DIM_W'(r_hx);
    assign bot_raw   = DIM_W'(r_i) + DIM_W'(r_hy);
    assign left_c  = (r_j >= POS_W'(r_hx)) ? COL_W'(r_j - POS_W'(r_hx)) : '0;
    assign top_c   = (r_i >= POS_W'(r_hy)) ? ROW_W'(r_i - POS_W'(r_hy)) : '0;
    assign right_c = (right_raw > col_lim) ? col_lim[COL_W-1:0] : right_raw[COL_W-1:0];
    assign bot_c   = (bot_raw > line_lim) ? line_lim[ROW_W-1:0] : bot_raw[ROW_W-1:0];
    assign empty   = (left_c > right_c) || (top_c > bot_c);

    assign adx = (r_x > COL_W'(r_j)) ? r_x - COL_W'(r_j) : COL_W'(r_j) - r_x;
    assign ady = (r_y > ROW_W'(r_i)) ? r_y - ROW_W'(r_i) : ROW_W'(r_i) - r_y;
    assign xd  = COL_W'(adx) * sxe;
    assign yd  = ROW_W'(ady) * sye;
    assign skip_xy = ({xd, 1'b0} >= (COL_W+WIN_W+1)'(r_win)) ||
                     ({yd, 1'b0} >= (ROW_W+WIN_W+1)'(r_win));
    assign is_nul  = (r_rd == r_null);

    assign last_pos = (r_x == r_right) && (r_y == r_bot);

    assign srem2  = {r_srem[SREM_W-3:0], r_rad[SQ_W-1:SQ_W-2]};
    assign strial = {r_root, 2'b01};
    assign sfits  = srem2 >= strial;

    assign far   = {r_root, 1'b0} >= (ROOT_W+1)'(r_win);
    assign wdiff = r_win - WIN_W'({r_root, 1'b0});

    assign mag    = r_sum[DIV_NUM_W-1] ? DIV_NUM_W'(-r_sum) : DIV_NUM_W'(r_sum);
    assign no_res = !r_nonnull || (r_wsum == '0);
    assign q      = div_rsp.quot;
    assign qs     = r_sum[DIV_NUM_W-1]
                  ? ((q > DIV_NUM_W'(64'h8000_0000)) ? 32'h8000_0000 : q[SMP_W-1:0])
                  : ((q > DIV_NUM_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[SMP_W-1:0]);

    always_comb begin
        n_state = r_state;
        advance = 1'b0;
        div_req = '0;
        unique case (r_state)
            S_IDLE: if (in_acc && i_in.operation) n_state = S_HALF;
            S_HALF: if (!adv_x && !adv_y) n_state = S_BOUND;
            S_BOUND: n_state = empty ? S_OUT : S_READ;
            S_READ: n_state = S_CHECK;
            S_CHECK: begin
                if (is_nul || skip_xy) begin
                    advance = 1'b1;
                end else begin
                    n_state = S_SQX;
                end
            end
            S_SQX: n_state = S_SQY;
            S_SQY: n_state = S_SQRT;
            S_SQRT: if (r_cnt == '0) n_state = S_WCHK;
            S_WCHK: begin
                if (far) begin
                    advance = 1'b1;
                end else begin
                    div_req.start = 1'b1;
                    div_req.nbits = DIV_CNT_W'(WIN_W + WEIGHT_BITS);
                    div_req.num   = DIV_NUM_W'({wdiff, WEIGHT_BITS'(0)});
                    div_req.den   = DIV_DEN_W'(r_win);
                    n_state = S_WDIV;
                end
            end
            S_WDIV: begin
                if (div_rsp.done) begin
                    if (q[W_W-1:0] == '0) advance = 1'b1;
                    else n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_ADD;
            S_ADD: advance = 1'b1;
            S_FIN: begin
                if (no_res) begin
                    n_state = S_OUT;
                end else begin
                    div_req.start = 1'b1;
                    div_req.nbits = DIV_CNT_W'(DIV_NUM_W);
                    div_req.num   = mag + DIV_NUM_W'(r_wsum >> 1);
                    div_req.den   = DIV_DEN_W'(r_wsum);
                    n_state = S_FDIV;
                end
            end
            S_FDIV: if (div_rsp.done) n_state = S_OUT;
            S_OUT: if (out_acc) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (advance) n_state = last_pos ? S_FIN : S_READ;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            if (r_x == r_right) begin
                r_x <= r_left;
                r_y <= r_y + ROW_W'(1);
            end else begin
                r_x <= r_x + COL_W'(1);
            end
        end
        unique case (r_state)
            S_IDLE: begin
                r_i   <= i_in.row;
                r_j   <= i_in.column;
                r_win <= i_in.window_width;
                r_hx  <= HALF_W'(1);
                r_hy  <= HALF_W'(1);
                r_ax  <= ACC_W'(two_sx);
                r_ay  <= ACC_W'(two_sy);
                r_sum <= '0;
                r_wsum <= '0;
                r_nonnull <= 1'b0;
            end
            S_HALF: begin
                if (adv_x) begin
                    r_hx <= r_hx + HALF_W'(1);
                    r_ax <= r_ax + ACC_W'(two_sx);
                end
                if (adv_y) begin
                    r_hy <= r_hy + HALF_W'(1);
                    r_ay <= r_ay + ACC_W'(two_sy);
                end
            end
            S_BOUND: begin
                r_left  <= left_c;
                r_right <= right_c;
                r_bot   <= bot_c;
                r_x     <= left_c;
                r_y     <= top_c;
                r_res      <= r_null;
                r_res_null <= 1'b1;
            end
            S_CHECK: begin
                if (!is_nul) r_nonnull <= 1'b1;
                r_xd <= xd[WIN_W-1:0];
                r_yd <= yd[WIN_W-1:0];
            end
            S_SQX: r_sq <= SQ_W'(r_xd * r_xd);
            S_SQY: begin
                r_rad  <= r_sq + SQ_W'(r_yd * r_yd);
                r_srem <= '0;
                r_root <= '0;
                r_cnt  <= 5'(ROOT_W - 1);
            end
            S_SQRT: begin
                r_rad  <= {r_rad[SQ_W-3:0], 2'b00};
                r_srem <= sfits ? srem2 - strial : srem2;
                r_root <= {r_root[ROOT_W-2:0], sfits};
                r_cnt  <= r_cnt - 5'd1;
            end
            S_WDIV: r_w <= q[W_W-1:0];
            S_MUL: r_prod <= $signed({1'b0, r_w}) * $signed(r_rd);
            S_ADD: begin
                r_sum  <= r_sum + DIV_NUM_W'(r_prod);
                r_wsum <= r_wsum + WSUM_W'(r_w);
            end
            S_FIN: begin
                r_res      <= r_null;
                r_res_null <= no_res;
            end
            S_FDIV: begin
                if (div_rsp.done) begin
                    r_res      <= r_sum[DIV_NUM_W-1] ? -qs : qs;
                    r_res_null <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    vcwf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

endmodule
